@@ sv/psst_pkg.sv @@
// shared types and constants of the per-state step size tuner
// no dependencies; imported by the top level, psst_front, psst_back and psst_div
package psst_pkg;

	localparam int TRIAL_W     = 3;
	localparam int STATE_W     = 8;
	localparam int ITER_W      = 31;
	localparam int STEP_W      = 32;
	localparam int CNT_W       = 16;
	localparam int FRAC_W      = 16;
	localparam int GAIN_FRAC_W = 12;
	// acceptance quotient reaches 1.0, so one bit above the fraction
	localparam int QUOT_W      = FRAC_W + 1;
	localparam int FACTOR_W    = 23;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_TUNE_PERIOD       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STOP_ITERATION    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN              = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ACCEPTANCE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_BOUND       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_BOUND       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BOUND_ENABLE      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STEP      = 3'd7;

	// classification of an accepted item
	localparam logic [1:0] OP_NULL = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_TUNE = 2'd2;

	typedef struct packed {
		logic [TRIAL_W-1:0] trial_index;
		logic [STATE_W-1:0] state_index;
		logic               move_accepted;
		logic               tuning_enabled;
		logic [ITER_W-1:0]  iteration;
	} in_item_t;

	typedef struct packed {
		logic signed [STEP_W-1:0] step_value;
		logic                     adjusted;
		logic                     saturated;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [TRIAL_W-1:0] trial_index;
		logic [STATE_W-1:0] state_index;
		logic               move_accepted;
	} op_t;

	typedef struct packed {
		logic [CNT_W-1:0]         tune_period;
		logic [CNT_W-1:0]         gain;
		logic [FRAC_W-1:0]        target_acceptance;
		logic signed [STEP_W-1:0] lower_bound;
		logic signed [STEP_W-1:0] upper_bound;
		logic                     bound_enable;
		logic signed [STEP_W-1:0] initial_step;
	} tune_cfg_t;

endpackage

@@ sv/per_state_step_size_tuner.sv @@
// Per-state step size tuner. Each transfer on the input queue reports one finished
// move and yields exactly one result, in order. An item that does not end a tuning
// period passes the back-end sequencer's idle and read states (table read, then result
// and, for a tuning item, count write-back); an out-of-range item is answered in idle;
// an item that ends a tuning period goes on through the bit-serial acceptance divider
// and the two registered multiplies, the rounding and the write-back that follow.
// After reset and after each write of initial_step the step table is refilled, one
// entry a cycle over all NUM_TRIAL_TYPES * NUM_SAMPLE_STATES entries (2048 by default);
// full stays high meanwhile while register writes are still taken.
// depends on psst_pkg, psst_front, psst_fifo, psst_back
module per_state_step_size_tuner #(
	parameter int NUM_TRIAL_TYPES   = 8,
	parameter int NUM_SAMPLE_STATES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  psst_pkg::in_item_t                  item,
	output logic                                full,
	output logic                                empty,
	input  logic                                pop,
	output psst_pkg::out_item_t                 result,
	input  logic                                cfg_we,
	input  logic [psst_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [psst_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import psst_pkg::*;

	tune_cfg_t                cfg_q;
	logic signed [STEP_W-1:0] stop_q;
	logic                     init_load_q;

	logic      op_push;
	op_t       op_in;
	logic      op_full;
	logic      op_empty;
	op_t       op_head;
	logic      op_pop;
	logic      busy;
	logic      res_full;
	logic      res_push;
	out_item_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tune_period       <= 16'd100;
			cfg_q.gain              <= 16'd4096;
			cfg_q.target_acceptance <= 16'd16384;
			cfg_q.lower_bound       <= 32'sd0;
			cfg_q.upper_bound       <= 32'sh7FFF_FFFF;
			cfg_q.bound_enable      <= 1'b0;
			cfg_q.initial_step      <= 32'sd65536;
			stop_q                  <= -32'sd1;
			init_load_q             <= 1'b0;
		end else begin
			init_load_q <= cfg_we && (cfg_index == REG_INITIAL_STEP);
			if (cfg_we) begin
				case (cfg_index)
					REG_TUNE_PERIOD:       cfg_q.tune_period <= cfg_data[CNT_W-1:0];
					REG_STOP_ITERATION:    stop_q <= cfg_data;
					REG_GAIN:              cfg_q.gain <= cfg_data[CNT_W-1:0];
					REG_TARGET_ACCEPTANCE: cfg_q.target_acceptance <= cfg_data[FRAC_W-1:0];
					REG_LOWER_BOUND:       cfg_q.lower_bound <= cfg_data;
					REG_UPPER_BOUND:       cfg_q.upper_bound <= cfg_data;
					REG_BOUND_ENABLE:      cfg_q.bound_enable <= cfg_data[0];
					REG_INITIAL_STEP:      cfg_q.initial_step <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	psst_front #(
		.NUM_TRIAL_TYPES   (NUM_TRIAL_TYPES),
		.NUM_SAMPLE_STATES (NUM_SAMPLE_STATES)
	) u_front (
		.push           (push),
		.item           (item),
		.full           (full),
		.stop_iteration (stop_q),
		.hold           (busy),
		.op_push        (op_push),
		.op             (op_in),
		.op_full        (op_full)
	);

	psst_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (2)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.din    (op_in),
		.full   (op_full),
		.pop    (op_pop),
		.dout   (op_head),
		.empty  (op_empty)
	);

	psst_back #(
		.NUM_TRIAL_TYPES   (NUM_TRIAL_TYPES),
		.NUM_SAMPLE_STATES (NUM_SAMPLE_STATES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.init_load (init_load_q),
		.busy      (busy),
		.op_valid  (!op_empty),
		.op        (op_head),
		.op_pop    (op_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	psst_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

@@ sv/psst_ram.sv @@
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies
module psst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/psst_fifo.sv @@
// small synchronous queue with full and empty flags
// no dependencies; used between front and back and on the result side
module psst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/psst_div.sv @@
// bit-serial divider for the acceptance ratio: floor(num * 2^16 / den), num <= den
// depends on psst_pkg; one quotient bit per cycle
module psst_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psst_pkg::CNT_W-1:0]  num,
	input  logic [psst_pkg::CNT_W-1:0]  den,
	output logic                        done,
	output logic [psst_pkg::QUOT_W-1:0] quot
);
	import psst_pkg::*;

	localparam int SW = $clog2(QUOT_W);

	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [QUOT_W-1:0] quot_q;
	logic [SW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;
	logic [CNT_W:0]    diff;

	assign ge   = (rem_q >= {1'b0, den_q});
	assign diff = ge ? rem_q - {1'b0, den_q} : rem_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			// remainder stays below den, so the shift cannot lose a bit
			rem_q  <= {diff[CNT_W-1:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == SW'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ sv/psst_front.sv @@
// front end: takes input items, checks the table index and the tuning window
// depends on psst_pkg; feeds classified operations into the queue to the back end
module psst_front #(
	parameter int NUM_TRIAL_TYPES   = 8,
	parameter int NUM_SAMPLE_STATES = 256
) (
	input  logic                               push,
	input  psst_pkg::in_item_t                 item,
	output logic                               full,
	input  logic signed [psst_pkg::STEP_W-1:0] stop_iteration,
	input  logic                               hold,
	output logic                               op_push,
	output psst_pkg::op_t                      op,
	input  logic                               op_full
);
	import psst_pkg::*;

	logic in_range;
	logic window_open;

	always_comb begin
		in_range = (32'(item.trial_index) < NUM_TRIAL_TYPES) &&
			(32'(item.state_index) < NUM_SAMPLE_STATES);
		// all ones in stop_iteration means tuning never stops
		window_open = (stop_iteration == -32'sd1) ||
			(stop_iteration > $signed({1'b0, item.iteration}));
		op.trial_index   = item.trial_index;
		op.state_index   = item.state_index;
		op.move_accepted = item.move_accepted;
		if (!in_range) begin
			op.kind = OP_NULL;
		end else if (item.tuning_enabled && window_open) begin
			op.kind = OP_TUNE;
		end else begin
			op.kind = OP_READ;
		end
	end

	assign full    = op_full | hold;
	assign op_push = push & ~full;

endmodule

@@ sv/psst_back.sv @@
// back end: table sequencer doing read, count update, ratio divide, scale and write-back
// depends on psst_pkg, psst_ram and psst_div; also runs the table fill after reset and after each initial step write
module psst_back #(
	parameter int NUM_TRIAL_TYPES   = 8,
	parameter int NUM_SAMPLE_STATES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psst_pkg::tune_cfg_t   cfg,
	input  logic                  init_load,
	output logic                  busy,
	input  logic                  op_valid,
	input  psst_pkg::op_t         op,
	output logic                  op_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output psst_pkg::out_item_t   res
);
	import psst_pkg::*;

	localparam int DEPTH = NUM_TRIAL_TYPES * NUM_SAMPLE_STATES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int P1_W  = (CNT_W + 1) + (QUOT_W + 1);
	localparam int P2_W  = STEP_W + FACTOR_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_FAC  = 3'd4;
	localparam logic [2:0] ST_MUL2 = 3'd5;
	localparam logic [2:0] ST_RND  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]                state_q;
	logic [1:0]                kind_q;
	logic                      acc_flag_q;
	logic [AW-1:0]             addr_q;
	logic signed [STEP_W-1:0]  step_q;
	logic signed [P1_W-1:0]    prod1_q;
	logic signed [FACTOR_W-1:0] factor_q;
	logic signed [P2_W-1:0]    prod2_q;
	logic signed [STEP_W-1:0]  nv_q;
	logic                      sat_q;

	logic                      sweep_q;
	logic                      sweep_cnt_q;
	logic [AW-1:0]             sweep_addr_q;

	logic [AW-1:0]             op_addr;
	logic                      take;
	logic [STEP_W-1:0]         step_rdata;
	logic [2*CNT_W-1:0]        cnt_rdata;
	logic                      step_we;
	logic [AW-1:0]             step_waddr;
	logic [STEP_W-1:0]         step_wdata;
	logic                      cnt_we;
	logic [AW-1:0]             cnt_waddr;
	logic [2*CNT_W-1:0]        cnt_wdata;
	logic                      fsm_step_we;
	logic                      fsm_cnt_we;
	logic [2*CNT_W-1:0]        fsm_cnt_wdata;

	logic [CNT_W:0]            att_n;
	logic [CNT_W:0]            acc_n;
	logic                      hit;
	logic                      div_start;
	logic                      div_done;
	logic [QUOT_W-1:0]         quot;
	logic signed [QUOT_W:0]    err;
	logic signed [P1_W-1:0]    p1_adj;
	logic signed [P1_W-1:0]    p1_shr;
	logic [FACTOR_W-1:0]       factor_n;
	logic signed [P2_W-1:0]    p2_adj;
	logic signed [P2_W-1:0]    p2_shr;
	logic                      over;
	logic [STEP_W-1:0]         nv_n;
	logic                      in_bounds;
	logic                      keep;

	assign op_addr = AW'(32'(op.trial_index) * NUM_SAMPLE_STATES + 32'(op.state_index));
	assign busy    = sweep_q | init_load;
	assign take    = (state_q == ST_IDLE) && op_valid && !res_full && !busy;
	assign op_pop  = take;

	assign att_n     = {1'b0, cnt_rdata[2*CNT_W-1:CNT_W]} + 1'b1;
	assign acc_n     = {1'b0, cnt_rdata[CNT_W-1:0]} + {{CNT_W{1'b0}}, acc_flag_q};
	assign hit       = (att_n == {1'b0, cfg.tune_period});
	assign div_start = (state_q == ST_READ) && (kind_q == OP_TUNE) && hit;

	psst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_n[CNT_W-1:0]),
		.den    (cfg.tune_period),
		.done   (div_done),
		.quot   (quot)
	);

	// rounding to nearest with ties away from zero: add half, or half less one when negative
	always_comb begin
		err      = $signed({1'b0, quot}) - $signed({2'b00, cfg.target_acceptance});
		p1_adj   = prod1_q + $signed({{(P1_W-GAIN_FRAC_W){1'b0}}, ~prod1_q[P1_W-1],
			{(GAIN_FRAC_W-1){prod1_q[P1_W-1]}}});
		p1_shr   = p1_adj >>> GAIN_FRAC_W;
		factor_n = p1_shr[FACTOR_W-1:0] + FACTOR_W'(1 << FRAC_W);
		p2_adj   = prod2_q + $signed({{(P2_W-FRAC_W){1'b0}}, ~prod2_q[P2_W-1],
			{(FRAC_W-1){prod2_q[P2_W-1]}}});
		p2_shr   = p2_adj >>> FRAC_W;
		over     = (p2_shr[P2_W-1:STEP_W-1] != {(P2_W-STEP_W+1){p2_shr[P2_W-1]}});
		if (!over) begin
			nv_n = p2_shr[STEP_W-1:0];
		end else if (p2_shr[P2_W-1]) begin
			nv_n = {1'b1, {(STEP_W-1){1'b0}}};
		end else begin
			nv_n = {1'b0, {(STEP_W-1){1'b1}}};
		end
		in_bounds = (nv_q <= cfg.upper_bound) && (nv_q >= cfg.lower_bound);
		keep      = !cfg.bound_enable || in_bounds;
	end

	always_comb begin
		res_push      = 1'b0;
		res           = '0;
		fsm_step_we   = 1'b0;
		fsm_cnt_we    = 1'b0;
		fsm_cnt_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				// out-of-range items answer at once with an all-zero result
				if (take && op.kind == OP_NULL) begin
					res_push = 1'b1;
				end
			end
			ST_READ: begin
				if (!div_start) begin
					res_push       = 1'b1;
					res.step_value = step_rdata;
				end
				if (kind_q == OP_TUNE && !hit) begin
					fsm_cnt_we = 1'b1;
					// attempt count passing its range clears both counts
					fsm_cnt_wdata = att_n[CNT_W] ? '0 :
						{att_n[CNT_W-1:0], acc_n[CNT_W-1:0]};
				end
			end
			ST_DONE: begin
				fsm_step_we    = keep;
				fsm_cnt_we     = 1'b1;
				res_push       = 1'b1;
				res.step_value = keep ? nv_q : step_q;
				res.adjusted   = 1'b1;
				res.saturated  = sat_q;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (sweep_q) begin
			step_we    = 1'b1;
			step_waddr = sweep_addr_q;
			step_wdata = cfg.initial_step;
			cnt_we     = sweep_cnt_q;
			cnt_waddr  = sweep_addr_q;
			cnt_wdata  = '0;
		end else begin
			step_we    = fsm_step_we;
			step_waddr = addr_q;
			step_wdata = nv_q;
			cnt_we     = fsm_cnt_we;
			cnt_waddr  = addr_q;
			cnt_wdata  = fsm_cnt_wdata;
		end
	end

	psst_ram #(
		.WIDTH (STEP_W),
		.DEPTH (DEPTH)
	) u_step_ram (
		.clk   (clk),
		.we    (step_we),
		.waddr (step_waddr),
		.wdata (step_wdata),
		.raddr (op_addr),
		.rdata (step_rdata)
	);

	psst_ram #(
		.WIDTH (2 * CNT_W),
		.DEPTH (DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (op_addr),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (take && op.kind != OP_NULL) begin
					state_q <= ST_READ;
				end
				ST_READ: state_q <= div_start ? ST_DIV : ST_IDLE;
				ST_DIV: if (div_done) begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_FAC;
				ST_FAC:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_RND;
				ST_RND:  state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q     <= op.kind;
			acc_flag_q <= op.move_accepted;
			addr_q     <= op_addr;
		end
		if (state_q == ST_READ) begin
			step_q <= step_rdata;
		end
		if (state_q == ST_MUL1) begin
			prod1_q <= $signed({1'b0, cfg.gain}) * err;
		end
		if (state_q == ST_FAC) begin
			factor_q <= factor_n;
		end
		if (state_q == ST_MUL2) begin
			prod2_q <= step_q * factor_q;
		end
		if (state_q == ST_RND) begin
			nv_q  <= nv_n;
			sat_q <= over;
		end
	end

	// fill of both tables after reset, and of the step table after every initial step write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_cnt_q  <= 1'b1;
			sweep_addr_q <= '0;
		end else if (init_load) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			if (sweep_addr_q == AW'(DEPTH - 1)) begin
				sweep_q     <= 1'b0;
				sweep_cnt_q <= 1'b0;
			end else begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
			end
		end
	end

	a_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> state_q == ST_IDLE)
		else $error("table fill overlaps an item in progress");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into a full queue");

	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> cfg.tune_period != '0)
		else $error("ratio divide started with zero period");

	a_mul_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL1 |-> $past(div_done))
		else $error("scaling started before the divide finished");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL1 |-> quot <= 17'h10000)
		else $error("acceptance ratio above one");

endmodule
